FILE: design/tmsf_pkg.sv
// shared widths and constants of the trimmed mean sample filter
package tmsf_pkg;

  // fixed field widths of the stream payloads
  localparam int unsigned ChanW      = 4;
  localparam int unsigned InSampleW  = 12;
  localparam int unsigned MeanW      = 14;
  localparam int unsigned SumW       = InSampleW + 3;

  // block of eight samples per channel, indexed by three bits
  localparam int unsigned BlockLen   = 8;
  localparam int unsigned SlotW      = 3;

  // packed stream widths, padded to whole bytes
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 24;

  // largest value the result field can carry
  localparam logic [MeanW-1:0] MeanMax = {MeanW{1'b1}};

  // running statistics gathered while a full block is read back
  typedef struct packed {
    logic [SumW-1:0]      total;
    logic [InSampleW-1:0] min1;
    logic [InSampleW-1:0] min2;
    logic [InSampleW-1:0] max1;
    logic [InSampleW-1:0] max2;
  } stats_t;

endpackage

FILE: design/trimmed_mean_sample_filter.sv
// trimmed mean sample filter: per-channel block of eight, mean of the middle four
//
// Samples come in on the s_axis channel, each tagged with its sensor channel.
// Every channel keeps its own block of eight samples in a shared sample memory.
// A sample that does not complete its channel's block gives no result. The
// eighth sample starts a readback of the block: one memory read
// per cycle feeds a single compare/add unit that keeps the running total and the
// two lowest and two highest values. The middle-four sum is total minus those
// four; it leaves on the m_axis channel as a Q.2 mean.
// A completing sample is written, then its eight slots are read back through the
// single read port of the sample memory, the last read data is taken in and the
// result is formed; s_axis_tready is low from then until the result is loaded.
// Samples on channels of CHANNELS or above are accepted and dropped.
// Reset clears all channel fill counts and the output valid flag; the sample
// memory needs no clearing since a slot is only read after it was written.
// The result sits in an output register: while the receiver stalls the block
// keeps accepting samples, and holds before loading a new result until the
// waiting one is taken.
module trimmed_mean_sample_filter #(
  parameter int unsigned CHANNELS    = 13,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] channel, [15:4] sample
  input  logic [tmsf_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] out_channel, [17:4] mean_q2, [23:18] zero
  output logic [tmsf_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW    = CW + tmsf_pkg::SlotW;
  localparam int unsigned Depth = CHANNELS * tmsf_pkg::BlockLen;
  localparam int unsigned SW    = (SAMPLE_BITS < tmsf_pkg::InSampleW) ?
                                  SAMPLE_BITS : tmsf_pkg::InSampleW;
  localparam logic [tmsf_pkg::InSampleW-1:0] SampleMask =
    tmsf_pkg::InSampleW'((33'(1) << SW) - 33'(1));

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRead   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;

  // input field split
  logic [tmsf_pkg::ChanW-1:0]     in_chan;
  logic [tmsf_pkg::InSampleW-1:0] in_sample;
  logic [CW-1:0]                  ch_idx;
  logic                           ch_ok;
  logic                           in_xfer;

  assign in_chan   = s_axis_tdata[tmsf_pkg::ChanW-1:0];
  assign in_sample = s_axis_tdata[tmsf_pkg::ChanW +: tmsf_pkg::InSampleW] & SampleMask;
  assign ch_idx    = CW'(in_chan);
  assign ch_ok     = (32'(in_chan) < 32'(CHANNELS));
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // per-channel fill counts
  logic [tmsf_pkg::SlotW-1:0] fill_q [CHANNELS];
  logic [tmsf_pkg::SlotW-1:0] pos;
  logic                       block_done;

  assign pos        = fill_q[ch_idx];
  assign block_done = in_xfer && ch_ok && (pos == tmsf_pkg::SlotW'(tmsf_pkg::BlockLen - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (in_xfer && ch_ok) begin
      fill_q[ch_idx] <= pos + 1'b1;
    end
  end

  // readback sequencing
  logic [CW-1:0]              rd_ch_q, rd_ch_d;
  logic [tmsf_pkg::SlotW-1:0] rd_cnt_q, rd_cnt_d;
  logic                       rd_en;
  logic                       rd_vld_q;

  always_comb begin
    state_d  = state_q;
    rd_ch_d  = rd_ch_q;
    rd_cnt_d = rd_cnt_q;
    rd_en    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (block_done) begin
          state_d  = StRead;
          rd_ch_d  = ch_idx;
          rd_cnt_d = '0;
        end
      end
      StRead: begin
        rd_en    = 1'b1;
        rd_cnt_d = rd_cnt_q + 1'b1;
        if (rd_cnt_q == tmsf_pkg::SlotW'(tmsf_pkg::BlockLen - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_cnt_q <= '0;
      rd_ch_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      rd_ch_q  <= rd_ch_d;
      rd_vld_q <= rd_en;
    end
  end

  // sample memory, one write and one registered read per cycle
  logic [tmsf_pkg::InSampleW-1:0] mem [Depth];
  logic [tmsf_pkg::InSampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && ch_ok) begin
      mem[{ch_idx, pos}] <= in_sample;
    end
    if (rd_en) begin
      rd_data_q <= mem[AW'({rd_ch_q, rd_cnt_q})];
    end
  end

  // shared compare/add unit over the read-back samples
  tmsf_pkg::stats_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (block_done) begin
      st_d.total = '0;
      st_d.min1  = '1;
      st_d.min2  = '1;
      st_d.max1  = '0;
      st_d.max2  = '0;
    end else if (rd_vld_q) begin
      st_d.total = st_q.total + tmsf_pkg::SumW'(rd_data_q);
      if (rd_data_q < st_q.min1) begin
        st_d.min2 = st_q.min1;
        st_d.min1 = rd_data_q;
      end else if (rd_data_q < st_q.min2) begin
        st_d.min2 = rd_data_q;
      end
      if (rd_data_q > st_q.max1) begin
        st_d.max2 = st_q.max1;
        st_d.max1 = rd_data_q;
      end else if (rd_data_q > st_q.max2) begin
        st_d.max2 = rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  // trimmed sum: total less the two lowest and two highest
  logic [tmsf_pkg::SumW-1:0]  drop_sum;
  logic [tmsf_pkg::SumW-1:0]  mid_sum;
  logic [tmsf_pkg::MeanW-1:0] mean;

  assign drop_sum = tmsf_pkg::SumW'(st_q.min1) + tmsf_pkg::SumW'(st_q.min2)
                  + tmsf_pkg::SumW'(st_q.max1) + tmsf_pkg::SumW'(st_q.max2);
  assign mid_sum  = st_q.total - drop_sum;
  assign mean     = (mid_sum > tmsf_pkg::SumW'(tmsf_pkg::MeanMax)) ?
                    tmsf_pkg::MeanMax : mid_sum[tmsf_pkg::MeanW-1:0];

  // output register
  logic                           out_vld_q;
  logic [tmsf_pkg::OutDataW-1:0]  out_data_q;
  logic                           out_load;

  assign out_load = (state_q == StFinish) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= tmsf_pkg::OutDataW'({mean, tmsf_pkg::ChanW'(rd_ch_q)});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
